// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define CTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define CTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Types and constants of the CAN transport segmenter.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int FRAME_LEN  = 8;
  localparam int MAX_SINGLE = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [7:0] FIRST_CTRL  = 8'h10;
  localparam logic [7:0] CONSEC_CTRL = 8'h20;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_IDENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE   = 1'd1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] message_length;
    logic       with_length_byte;
  } seg_in_t;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [7:0]  frame_byte0;
    logic [7:0]  frame_byte1;
    logic [7:0]  frame_byte2;
    logic [7:0]  frame_byte3;
    logic [7:0]  frame_byte4;
    logic [7:0]  frame_byte5;
    logic [7:0]  frame_byte6;
    logic [7:0]  frame_byte7;
    logic        final_frame;
  } seg_out_t;

endpackage

// ===== rtl/can_transport_segmenter.sv =====
// ----------------------------------------------------------------------------
// can_transport_segmenter
// Packs a byte stream into padded eight-byte CAN frames, single or segmented.
// ----------------------------------------------------------------------------
// Output: a completed frame is registered in out_data or the skid register.
// Throughput: one payload word per cycle while the skid register is empty; a
//   two-entry output stage keeps input open while one frame waits in it.
// Reset: rst (synchronous) clears the message state, both output valids and
//   the configuration registers; frame buffer contents are not cleared.
module can_transport_segmenter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cts_pkg::seg_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cts_pkg::seg_out_t               out_data
);

  // configuration registers
  logic [10:0] frame_ident;
  logic [7:0]  pad_value;

  // message state
  logic [7:0]  frame_bytes [cts_pkg::FRAME_LEN];
  logic [2:0]  slot_position;
  logic [3:0]  frame_index;   // all four bits form the low nibble of the control byte
  logic [7:0]  bytes_left;
  logic        in_message;

  // output stage
  cts_pkg::seg_out_t skid_data;
  logic              skid_valid;

  // per-word decode
  logic        in_acc;
  logic        start;
  logic        zero_len;
  logic        single;
  logic [2:0]  pos;
  logic [7:0]  left_eff;
  logic [7:0]  left_after;
  logic [3:0]  index_eff;
  logic        last_byte;
  logic        full;
  logic        emit;
  logic [3:0]  filled;
  logic [7:0]  wb [cts_pkg::FRAME_LEN];   // buffer after this word's writes
  logic [7:0]  ob [cts_pkg::FRAME_LEN];   // frame bytes with padding
  cts_pkg::seg_out_t res;

  logic [2:0]  slot_position_next;
  logic [3:0]  frame_index_next;
  logic [7:0]  bytes_left_next;
  logic        in_message_next;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;

  always_comb begin
    start     = !in_message;
    zero_len  = start && (in_data.message_length == 8'd0);
    single    = in_data.message_length <= 8'(cts_pkg::MAX_SINGLE);

    // slot taken by this word; a new message opens after its header
    if (start) begin
      if (single) begin
        pos = in_data.with_length_byte ? 3'd1 : 3'd0;
      end else begin
        pos = 3'd2;
      end
      left_eff  = in_data.message_length;
      index_eff = 4'd0;
    end else begin
      pos       = slot_position;
      left_eff  = bytes_left;
      index_eff = frame_index;
    end

    left_after = left_eff - 8'd1;
    last_byte  = !zero_len && (left_after == 8'd0);
    full       = !zero_len && (pos == 3'(cts_pkg::FRAME_LEN - 1));
    emit       = zero_len || last_byte || full;

    if (zero_len) begin
      filled = {3'd0, in_data.with_length_byte};
    end else if (last_byte) begin
      filled = {1'b0, pos} + 4'd1;
    end else begin
      filled = 4'(cts_pkg::FRAME_LEN);
    end

    // apply header and data writes of this word
    for (int j = 0; j < cts_pkg::FRAME_LEN; j++) begin
      wb[j] = frame_bytes[j];
    end
    if (zero_len) begin
      if (in_data.with_length_byte) begin
        wb[0] = 8'd0;
      end
    end else begin
      if (start) begin
        if (single) begin
          if (in_data.with_length_byte) begin
            wb[0] = in_data.message_length;
          end
        end else begin
          wb[0] = cts_pkg::FIRST_CTRL;
          wb[1] = in_data.message_length;
        end
      end
      wb[pos] = in_data.payload_byte;
    end

    // pad the unused tail
    for (int j = 0; j < cts_pkg::FRAME_LEN; j++) begin
      ob[j] = (4'(j) < filled) ? wb[j] : pad_value;
    end

    res.frame_id    = frame_ident;
    res.frame_byte0 = ob[0];
    res.frame_byte1 = ob[1];
    res.frame_byte2 = ob[2];
    res.frame_byte3 = ob[3];
    res.frame_byte4 = ob[4];
    res.frame_byte5 = ob[5];
    res.frame_byte6 = ob[6];
    res.frame_byte7 = ob[7];
    res.final_frame = zero_len || last_byte;

    // next message state
    slot_position_next = slot_position;
    frame_index_next   = frame_index;
    bytes_left_next    = bytes_left;
    in_message_next    = in_message;
    if (zero_len) begin
      slot_position_next = 3'd0;
    end else begin
      bytes_left_next = left_after;
      if (last_byte) begin
        // drop back to idle
        in_message_next    = 1'b0;
        slot_position_next = 3'd0;
        frame_index_next   = index_eff;
      end else if (full) begin
        // advance to the next consecutive frame, byte 0 holds its header
        in_message_next    = 1'b1;
        frame_index_next   = index_eff + 4'd1;
        slot_position_next = 3'd1;
      end else begin
        in_message_next    = 1'b1;
        frame_index_next   = index_eff;
        slot_position_next = pos + 3'd1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ident <= '0;
      pad_value   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cts_pkg::REG_FRAME_IDENT: frame_ident <= cfg_data;
        cts_pkg::REG_PAD_VALUE:   pad_value   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_position <= '0;
      frame_index   <= '0;
      bytes_left    <= '0;
      in_message    <= 1'b0;
    end else if (in_acc) begin
      slot_position <= slot_position_next;
      frame_index   <= frame_index_next;
      bytes_left    <= bytes_left_next;
      in_message    <= in_message_next;
    end
  end

  // frame buffer, no reset; a full mid-message frame reopens with its header
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int j = 0; j < cts_pkg::FRAME_LEN; j++) begin
        if (j == 0 && full && !last_byte) begin
          frame_bytes[j] <= cts_pkg::CONSEC_CTRL | {4'd0, frame_index_next};
        end else begin
          frame_bytes[j] <= wb[j];
        end
      end
    end
  end

  // output register with skid: a new frame lands in out_data when it is free or
  // being taken this cycle and no frame waits in skid, else in the skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= in_acc && emit;
          skid_data  <= res;
        end else begin
          out_valid <= in_acc && emit;
          out_data  <= res;
        end
      end else if (in_acc && emit) begin
        skid_valid <= 1'b1;
        skid_data  <= res;
      end
    end
  end

endmodule

// ===== rtl/cts_checker.sv =====
// ----------------------------------------------------------------------------
// cts_checker
// Port-level checks of the CAN transport segmenter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cts_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input cts_pkg::seg_out_t out_data
);

  // a stalled frame holds
  `CTS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled frame changed")

  // input only stalls behind a frame that was held back
  `CTS_ASSERT(a_stall_cause, clk, rst, in_stall |-> $past(out_valid && out_stall), "input stall without output back-pressure")

  // every frame that is not final opens with a first or consecutive header
  `CTS_ASSERT(a_mid_header, clk, rst, out_valid && !out_data.final_frame |-> out_data.frame_byte0 == cts_pkg::FIRST_CTRL || out_data.frame_byte0[7:4] == cts_pkg::CONSEC_CTRL[7:4], "bad header on non-final frame")

  // reset leaves the input open and no frame valid
  `CTS_ASSERT_ALWAYS(a_reset_open, clk, rst |=> !in_stall && !out_valid, "stage not cleared by reset")

endmodule

bind can_transport_segmenter cts_checker u_cts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
